FILE: hdl/ets_pkg.sv
package ets_pkg;

   localparam int ETS_MEAN_FRAC_BITS = 16;
   localparam int WORD_W = 64;
   localparam int MEAN_W = 48;
   localparam int STAMP_W = 32;
   localparam int PROD_W = 2 * MEAN_W;
   localparam int KIND_W = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // counter kinds
   localparam logic [KIND_W-1:0] KIND_COUNT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ELAPSED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INTERVAL = 2'd2;

   // request codes
   localparam logic [2:0] REQ_EVENT   = 3'd0;
   localparam logic [2:0] REQ_BEGIN   = 3'd1;
   localparam logic [2:0] REQ_END     = 3'd2;
   localparam logic [2:0] REQ_CANCEL  = 3'd3;
   localparam logic [2:0] REQ_SET_EL  = 3'd4;
   localparam logic [2:0] REQ_SET_CNT = 3'd5;
   localparam logic [2:0] REQ_RESET   = 3'd6;

   // register index
   localparam logic [0:0] REG_KIND = 1'b0;

   typedef struct packed {
      logic [2:0]               req_type;
      logic [WORD_W-1:0]        now_us;
      logic signed [WORD_W-1:0] elapsed_us;
      logic [WORD_W-1:0]        count_value;
   } ets_req_pkt_type;

   typedef struct packed {
      logic [WORD_W-1:0]  evt_tally;
      logic [WORD_W-1:0]  span_sum;
      logic [STAMP_W-1:0] span_min;
      logic [STAMP_W-1:0] span_max;
      logic [MEAN_W-1:0]  mean_q16;
      logic [WORD_W-1:0]  sq_dev_sum;
      logic [WORD_W-1:0]  first_time;
      logic [WORD_W-1:0]  last_time;
      logic               timing_open;
   } ets_rsp_pkt_type;

   typedef struct packed {
      logic start;
      logic op_mul;
   } ets_cmd_type;

endpackage

FILE: hdl/event_timing_statistics.sv
// Each accepted request steps through EXEC and QNT to FIN; a statistics update adds
// DELTA, where the first interval loads the mean. Updating the running mean and the
// deviation sum adds DIV, MEAN, RMAG, MUL and ACC (48-step divide and 48-step multiply
// on one shared shift/add unit); a wrapped count skips the divide.
// One request at a time; the next is taken once the result is queued.
// Reset (synchronous, active high) clears all statistics, kind 0.
module event_timing_statistics #(
   parameter int MEAN_FRAC_BITS = ets_pkg::ETS_MEAN_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ets_pkg::ets_req_pkt_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ets_pkg::ets_rsp_pkt_type             rsp_payload,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ets_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [ets_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [ets_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import ets_pkg::*;

   logic [KIND_W-1:0] kind_ff;
   logic              rsp_valid_ff;
   ets_rsp_pkt_type   rsp_ff;
   logic              core_idle;
   logic              core_fin;
   logic              out_free;
   ets_rsp_pkt_type   snap;
   logic              reg_sel;

   assign reg_sel  = (paddr[CSR_ADDR_W-1:2] == REG_KIND);
   assign pready   = 1'b1;
   assign prdata   = reg_sel ? {{(CSR_DATA_W-KIND_W){1'b0}}, kind_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_COUNT;
      end else if (psel && penable && pwrite && reg_sel) begin
         kind_ff <= pwdata[KIND_W-1:0];
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !core_idle;

   ets_core #(
      .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid && core_idle),
      .req      (req_payload),
      .kind     (kind_ff),
      .out_free (out_free),
      .idle     (core_idle),
      .fin      (core_fin),
      .snap     (snap)
   );

   // hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_fin && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_fin && out_free) begin
         rsp_ff <= snap;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hdl/ets_iter_unit.sv
module ets_iter_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  ets_pkg::ets_cmd_type       cmd,
   input  logic [ets_pkg::MEAN_W-1:0] opa,
   input  logic [ets_pkg::WORD_W-1:0] opb,
   output logic                       done,
   output logic [ets_pkg::PROD_W-1:0] result
);
   import ets_pkg::*;

   localparam int STEPS = MEAN_W;
   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

   logic [WORD_W-1:0] hi_ff, hi_in;
   logic [MEAN_W-1:0] lo_ff, lo_in;
   logic [WORD_W-1:0] b_ff;
   logic              op_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [WORD_W:0]   add_a, add_b;
   logic              cin;
   logic [WORD_W+1:0] sum;
   logic              ge;

   // one adder serves both the restoring divide and the shift-add multiply
   always_comb begin
      if (op_ff) begin
         add_a = {{(WORD_W+1-MEAN_W){1'b0}}, hi_ff[MEAN_W-1:0]};
         add_b = lo_ff[0] ? {{(WORD_W+1-MEAN_W){1'b0}}, b_ff[MEAN_W-1:0]} : '0;
         cin   = 1'b0;
      end else begin
         add_a = {hi_ff, lo_ff[MEAN_W-1]};
         add_b = ~{1'b0, b_ff};
         cin   = 1'b1;
      end
      sum = {1'b0, add_a} + {1'b0, add_b} + (WORD_W+2)'(cin);
      ge  = sum[WORD_W+1];
      if (op_ff) begin
         hi_in = {{(WORD_W-MEAN_W){1'b0}}, sum[MEAN_W:1]};
         lo_in = {sum[0], lo_ff[MEAN_W-1:1]};
      end else begin
         hi_in = ge ? sum[WORD_W-1:0] : add_a[WORD_W-1:0];
         lo_in = {lo_ff[MEAN_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hi_ff <= '0;
         lo_ff <= opa;
         b_ff  <= opb;
         op_ff <= cmd.op_mul;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign done   = done_ff;
   assign result = op_ff ? {hi_ff[MEAN_W-1:0], lo_ff} : {{(PROD_W-MEAN_W){1'b0}}, lo_ff};

endmodule

FILE: hdl/ets_core.sv
module ets_core #(
   parameter int MEAN_FRAC_BITS = ets_pkg::ETS_MEAN_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  ets_pkg::ets_req_pkt_type     req,
   input  logic [ets_pkg::KIND_W-1:0]   kind,
   input  logic                         out_free,
   output logic                         idle,
   output logic                         fin,
   output ets_pkg::ets_rsp_pkt_type     snap
);
   import ets_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EXEC  = 4'd1;
   localparam logic [3:0] S_QNT   = 4'd2;
   localparam logic [3:0] S_DELTA = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_MEAN  = 4'd5;
   localparam logic [3:0] S_RMAG  = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_ACC   = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;

   localparam logic [MEAN_W-1:0] MEAN_MAX = '1;
   localparam logic [WORD_W-1:0] QLIM = WORD_W'(MEAN_MAX >> MEAN_FRAC_BITS);
   localparam int PSHIFT = 2 * MEAN_FRAC_BITS;

   logic [3:0] state_ff, state_in;

   ets_req_pkt_type    rq_ff;
   logic [KIND_W-1:0]  kind_ff;

   logic [WORD_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0]  start_ff, start_in;
   logic [WORD_W-1:0]  total_ff, total_in;
   logic [STAMP_W-1:0] least_ff, least_in;
   logic [STAMP_W-1:0] most_ff, most_in;
   logic [MEAN_W-1:0]  mean_ff, mean_in;
   logic [WORD_W-1:0]  dev_ff, dev_in;
   logic [WORD_W-1:0]  first_ff, first_in;
   logic [WORD_W-1:0]  last_ff, last_in;

   logic               wf_ff, wf_in;
   logic               setm_ff, setm_in;
   logic [WORD_W-1:0]  x_ff, x_in;
   logic [WORD_W-1:0]  n_ff, n_in;
   logic [MEAN_W-1:0]  xq_ff, xq_in;
   logic               up_ff, up_in;
   logic [MEAN_W-1:0]  dmag_ff, dmag_in;

   ets_cmd_type        cmd;
   logic [MEAN_W-1:0]  opa;
   logic [WORD_W-1:0]  opb;
   logic               unit_done;
   logic [PROD_W-1:0]  unit_res;

   logic [WORD_W-1:0]  e_val, d_val;
   logic [STAMP_W-1:0] e32, d32;
   logic [PROD_W-1:0]  prod_sh;
   logic [WORD_W-1:0]  add_val;
   logic [WORD_W:0]    dev_sum;
   logic [MEAN_W-1:0]  rmag;

   ets_iter_unit u_iter (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (opa),
      .opb    (opb),
      .done   (unit_done),
      .result (unit_res)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      start_in = start_ff;
      total_in = total_ff;
      least_in = least_ff;
      most_in  = most_ff;
      mean_in  = mean_ff;
      dev_in   = dev_ff;
      first_in = first_ff;
      last_in  = last_ff;
      wf_in    = wf_ff;
      setm_in  = setm_ff;
      x_in     = x_ff;
      n_in     = n_ff;
      xq_in    = xq_ff;
      up_in    = up_ff;
      dmag_in  = dmag_ff;
      cmd      = '0;
      opa      = dmag_ff;
      opb      = n_ff;
      rmag     = '0;
      prod_sh  = '0;
      add_val  = '0;
      dev_sum  = '0;

      e_val = (rq_ff.req_type == REQ_END) ? rq_ff.now_us - start_ff
                                          : WORD_W'(rq_ff.elapsed_us);
      e32   = e_val[STAMP_W-1:0];
      d_val = rq_ff.now_us - last_ff;
      d32   = d_val[STAMP_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            wf_in   = 1'b0;
            setm_in = 1'b0;
            case (kind_ff)
               KIND_COUNT: begin
                  if (rq_ff.req_type == REQ_EVENT) begin
                     count_in = count_ff + 1'b1;
                  end else if (rq_ff.req_type == REQ_SET_CNT) begin
                     count_in = rq_ff.count_value;
                  end else if (rq_ff.req_type == REQ_RESET) begin
                     count_in = '0;
                  end
               end
               KIND_ELAPSED: begin
                  if (rq_ff.req_type == REQ_BEGIN) begin
                     start_in = rq_ff.now_us;
                  end else if (rq_ff.req_type == REQ_CANCEL) begin
                     start_in = '0;
                  end else if (rq_ff.req_type == REQ_RESET) begin
                     count_in = '0;
                     start_in = '0;
                     total_in = '0;
                     least_in = '0;
                     most_in  = '0;
                     mean_in  = '0;
                     dev_in   = '0;
                  end else if ((rq_ff.req_type == REQ_SET_EL ||
                               (rq_ff.req_type == REQ_END && start_ff != '0)) &&
                               !e_val[WORD_W-1]) begin
                     count_in = count_ff + 1'b1;
                     total_in = total_ff + e_val;
                     if (least_ff > e32 || least_ff == '0) begin
                        least_in = e32;
                     end
                     if (most_ff < e32) begin
                        most_in = e32;
                     end
                     start_in = '0;
                     wf_in    = 1'b1;
                     x_in     = e_val;
                     n_in     = count_ff + 1'b1;
                  end
               end
               KIND_INTERVAL: begin
                  if (rq_ff.req_type == REQ_EVENT) begin
                     if (count_ff == '0) begin
                        first_in = rq_ff.now_us;
                     end else if (count_ff == WORD_W'(1)) begin
                        least_in = d32;
                        most_in  = d32;
                        setm_in  = 1'b1;
                        x_in     = d_val;
                     end else begin
                        if (d32 < least_ff) begin
                           least_in = d32;
                        end
                        if (d32 > most_ff) begin
                           most_in = d32;
                        end
                        wf_in = 1'b1;
                        x_in  = d_val;
                        n_in  = count_ff;
                     end
                     last_in  = rq_ff.now_us;
                     count_in = count_ff + 1'b1;
                  end else if (rq_ff.req_type == REQ_RESET) begin
                     count_in = '0;
                     first_in = '0;
                     last_in  = '0;
                     least_in = '0;
                     most_in  = '0;
                     mean_in  = '0;
                     dev_in   = '0;
                  end
               end
               default: begin
               end
            endcase
            state_in = S_QNT;
         end
         S_QNT: begin
            // saturate the scaled sample to the mean width
            if (x_ff > QLIM) begin
               xq_in = MEAN_MAX;
            end else begin
               xq_in = MEAN_W'(x_ff << MEAN_FRAC_BITS);
            end
            state_in = (wf_ff || setm_ff) ? S_DELTA : S_FIN;
         end
         S_DELTA: begin
            if (setm_ff) begin
               mean_in  = xq_ff;
               dev_in   = '0;
               state_in = S_FIN;
            end else begin
               up_in   = xq_ff >= mean_ff;
               dmag_in = (xq_ff >= mean_ff) ? xq_ff - mean_ff : mean_ff - xq_ff;
               opa     = dmag_in;
               opb     = n_ff;
               if (n_ff == '0) begin
                  // wrapped count: hold the mean
                  state_in = S_RMAG;
               end else begin
                  cmd.start  = 1'b1;
                  cmd.op_mul = 1'b0;
                  state_in   = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (unit_done) begin
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            mean_in  = up_ff ? mean_ff + unit_res[MEAN_W-1:0]
                             : mean_ff - unit_res[MEAN_W-1:0];
            state_in = S_RMAG;
         end
         S_RMAG: begin
            rmag       = (xq_ff >= mean_ff) ? xq_ff - mean_ff : mean_ff - xq_ff;
            opa        = dmag_ff;
            opb        = {{(WORD_W-MEAN_W){1'b0}}, rmag};
            cmd.start  = 1'b1;
            cmd.op_mul = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            if (unit_done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            prod_sh = unit_res >> PSHIFT;
            add_val = (|prod_sh[PROD_W-1:WORD_W]) ? '1 : prod_sh[WORD_W-1:0];
            dev_sum = {1'b0, dev_ff} + {1'b0, add_val};
            dev_in  = dev_sum[WORD_W] ? '1 : dev_sum[WORD_W-1:0];
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         start_ff <= '0;
         total_ff <= '0;
         least_ff <= '0;
         most_ff  <= '0;
         mean_ff  <= '0;
         dev_ff   <= '0;
         first_ff <= '0;
         last_ff  <= '0;
         wf_ff    <= 1'b0;
         setm_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         start_ff <= start_in;
         total_ff <= total_in;
         least_ff <= least_in;
         most_ff  <= most_in;
         mean_ff  <= mean_in;
         dev_ff   <= dev_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         wf_ff    <= wf_in;
         setm_ff  <= setm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         rq_ff   <= req;
         kind_ff <= kind;
      end
      x_ff    <= x_in;
      n_ff    <= n_in;
      xq_ff   <= xq_in;
      up_ff   <= up_in;
      dmag_ff <= dmag_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign fin  = (state_ff == S_FIN);

   always_comb begin
      snap.evt_tally   = count_ff;
      snap.span_sum    = total_ff;
      snap.span_min    = least_ff;
      snap.span_max    = most_ff;
      snap.mean_q16    = mean_ff;
      snap.sq_dev_sum  = dev_ff;
      snap.first_time  = first_ff;
      snap.last_time   = last_ff;
      snap.timing_open = (start_ff != '0);
   end

endmodule
